/* rtl/tensor_axis_max_reduce_assert.svh */
// Assertion macros used by the axis max-reduce RTL.
// Each expects clk and rst_n in scope at the point of use.
`ifndef TENSOR_AXIS_MAX_REDUCE_ASSERT_SVH
`define TENSOR_AXIS_MAX_REDUCE_ASSERT_SVH

// same-cycle implication
`define TAMR_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tamr: assertion failed");

// next-cycle implication
`define TAMR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tamr: assertion failed");

`endif

/* rtl/tamr_pkg.sv */
// Shared constants and types for the axis max-reduce block.
// No dependencies.
`default_nettype none

package tamr_pkg;

    localparam int INNER_MAX_DEF  = 1024;
    localparam int ELEM_WIDTH_DEF = 32;

    localparam int DATA_W      = 32;  // element and result beat width
    localparam int CFG_W       = 25;  // widest register
    localparam int CFG_IDX_W   = 2;
    localparam int INNER_CFG_W = 11;
    localparam int KIND_W      = 2;
    localparam int POS_W       = 24;  // outer/axis position counters

    localparam logic [CFG_W-1:0] COUNT_HIGH = 25'h100_0000;

    localparam logic [CFG_IDX_W-1:0] REG_OUTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KIND  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_SIGNED   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UNSIGNED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLOAT    = 2'd2;

    typedef struct packed {
        logic first;  // first element along the axis: load
        logic emit;   // last element along the axis: produce a result
        logic last;   // final result of the tensor
    } tamr_flags_t;

endpackage

`default_nettype wire

/* rtl/tamr_stream_if.sv */
// Valid/ready stream interfaces for element beats and result beats.
// Depends on tamr_pkg.
`default_nettype none

interface tamr_elem_if
    import tamr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] element_bits;

    modport source (output valid, output element_bits, input ready);
    modport sink   (input valid, input element_bits, output ready);
endinterface

interface tamr_max_if
    import tamr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] max_bits;
    logic              last_output;

    modport source (output valid, output max_bits, output last_output, input ready);
    modport sink   (input valid, input max_bits, input last_output, output ready);
endinterface

`default_nettype wire

/* rtl/tensor_axis_max_reduce.sv */
// Top level of the axis max-reduce block: shape counters, partial-max RAM
// and compare/output stage. Depends on tamr_pkg, tamr_stream_if, tamr_ram,
// tamr_ctrl and tamr_update.
//
//   port       dir   beat
//   elements   sink  element_bits (32)
//   results    src   max_bits (32), last_output (1)
//   cfg_*      in    cfg_wr_en, cfg_index (2), cfg_data (25)
//
// One element per cycle unless elements stall; the partial-max RAM is read
// when a beat is taken and written back on the next cycle, with the previous
// write forwarded. A result is offered from the output FIFO after compare.
// Elements stall once queued results plus the one in compare reach four.
// Reset needs no clearing pass: an axis start always loads its entry.
// Any register write restarts the tensor at position zero.
`default_nettype none

module tensor_axis_max_reduce
    import tamr_pkg::*;
#(
    parameter int INNER_MAX  = INNER_MAX_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    tamr_elem_if.sink                 elements,
    tamr_max_if.source                results
);

    localparam int IDX_W = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;

    logic                  accept;
    logic [ELEM_WIDTH-1:0] elem;
    logic [IDX_W-1:0]      idx;
    tamr_flags_t           flags;
    logic [KIND_W-1:0]     kind;
    logic [ELEM_WIDTH-1:0] ram_rd_data;
    logic                  ram_wr_en;
    logic [IDX_W-1:0]      ram_wr_addr;
    logic [ELEM_WIDTH-1:0] ram_wr_data;
    logic                  in_ready;

    assign elements.ready = in_ready;
    assign accept         = elements.valid && in_ready;
    assign elem           = ELEM_WIDTH'(elements.element_bits);

    tamr_ctrl #(
        .INNER_MAX (INNER_MAX)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .idx       (idx),
        .flags     (flags),
        .kind      (kind)
    );

    tamr_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (INNER_MAX)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (idx),
        .rd_data (ram_rd_data)
    );

    tamr_update #(
        .INNER_MAX  (INNER_MAX),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .elem      (elem),
        .idx       (idx),
        .flags     (flags),
        .kind      (kind),
        .rd_data   (ram_rd_data),
        .wr_en     (ram_wr_en),
        .wr_addr   (ram_wr_addr),
        .wr_data   (ram_wr_data),
        .in_ready  (in_ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_max   (results.max_bits),
        .out_last  (results.last_output)
    );

endmodule

`default_nettype wire

/* rtl/tamr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Read-first on a same-address collision. No dependencies.
`default_nettype none

module tamr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output      logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/tamr_ctrl.sv */
// Shape registers and position counters; tags each element with its
// buffer index and first/emit/last flags. Depends on tamr_pkg.
`default_nettype none

module tamr_ctrl
    import tamr_pkg::*;
#(
    parameter int INNER_MAX = INNER_MAX_DEF,
    localparam int IDX_W    = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 accept,
    output      logic [IDX_W-1:0]     idx,
    output      tamr_flags_t          flags,
    output      logic [KIND_W-1:0]    kind
);

    localparam logic [IDX_W-1:0] INNER_TOP = IDX_W'(INNER_MAX - 1);

    // counts are held as their last position (count - 1)
    logic [POS_W-1:0]  outer_last_reg, outer_last_next;
    logic [POS_W-1:0]  axis_last_reg, axis_last_next;
    logic [IDX_W-1:0]  inner_last_reg, inner_last_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [IDX_W-1:0]  inner_pos_reg, inner_pos_next;
    logic [POS_W-1:0]  axis_pos_reg, axis_pos_next;
    logic [POS_W-1:0]  outer_pos_reg, outer_pos_next;

    logic inner_wrap, axis_wrap, outer_wrap;

    // zero acts as one, oversize saturates
    function automatic logic [POS_W-1:0] long_last(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] m;
        begin
            m = v - CFG_W'(1);
            if (v == '0)
            begin
                long_last = '0;
            end
            else if (v > COUNT_HIGH)
            begin
                long_last = '1;
            end
            else
            begin
                long_last = m[POS_W-1:0];
            end
        end
    endfunction

    function automatic logic [IDX_W-1:0] inner_last_of(input logic [INNER_CFG_W-1:0] v);
        logic [INNER_CFG_W-1:0] m;
        begin
            m = v - INNER_CFG_W'(1);
            if (v == '0)
            begin
                inner_last_of = '0;
            end
            else if (32'(v) > 32'(INNER_MAX))
            begin
                inner_last_of = INNER_TOP;
            end
            else
            begin
                inner_last_of = IDX_W'(m);
            end
        end
    endfunction

    assign inner_wrap = (inner_pos_reg == inner_last_reg);
    assign axis_wrap  = (axis_pos_reg == axis_last_reg);
    assign outer_wrap = (outer_pos_reg == outer_last_reg);

    assign idx         = inner_pos_reg;
    assign kind        = kind_reg;
    assign flags.first = (axis_pos_reg == '0);
    assign flags.emit  = axis_wrap;
    assign flags.last  = inner_wrap && outer_wrap;

    always_comb
    begin
        outer_last_next = outer_last_reg;
        axis_last_next  = axis_last_reg;
        inner_last_next = inner_last_reg;
        kind_next       = kind_reg;
        inner_pos_next  = inner_pos_reg;
        axis_pos_next   = axis_pos_reg;
        outer_pos_next  = outer_pos_reg;

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_OUTER: outer_last_next = long_last(cfg_data);
                REG_AXIS:  axis_last_next  = long_last(cfg_data);
                REG_INNER: inner_last_next = inner_last_of(cfg_data[INNER_CFG_W-1:0]);
                REG_KIND:  kind_next       = cfg_data[KIND_W-1:0];
                default:   ;
            endcase
            // any write starts a new tensor
            inner_pos_next = '0;
            axis_pos_next  = '0;
            outer_pos_next = '0;
        end
        else if (accept)
        begin
            if (!inner_wrap)
            begin
                inner_pos_next = inner_pos_reg + IDX_W'(1);
            end
            else
            begin
                inner_pos_next = '0;
                if (!axis_wrap)
                begin
                    axis_pos_next = axis_pos_reg + POS_W'(1);
                end
                else
                begin
                    axis_pos_next  = '0;
                    outer_pos_next = outer_wrap ? '0 : outer_pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_last_reg <= '0;
            axis_last_reg  <= '0;
            inner_last_reg <= '0;
            kind_reg       <= KIND_SIGNED;
            inner_pos_reg  <= '0;
            axis_pos_reg   <= '0;
            outer_pos_reg  <= '0;
        end
        else
        begin
            outer_last_reg <= outer_last_next;
            axis_last_reg  <= axis_last_next;
            inner_last_reg <= inner_last_next;
            kind_reg       <= kind_next;
            inner_pos_reg  <= inner_pos_next;
            axis_pos_reg   <= axis_pos_next;
            outer_pos_reg  <= outer_pos_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/tamr_update.sv */
// Compare stage: forwards the last buffer write, picks the new maximum,
// writes it back and queues results in a small output FIFO.
// Depends on tamr_pkg and tensor_axis_max_reduce_assert.svh.
`default_nettype none

module tamr_update
    import tamr_pkg::*;
#(
    parameter int INNER_MAX  = INNER_MAX_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    localparam int IDX_W     = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic [ELEM_WIDTH-1:0] elem,
    input  wire logic [IDX_W-1:0]      idx,
    input  wire tamr_flags_t           flags,
    input  wire logic [KIND_W-1:0]     kind,
    input  wire logic [ELEM_WIDTH-1:0] rd_data,
    output      logic                  wr_en,
    output      logic [IDX_W-1:0]      wr_addr,
    output      logic [ELEM_WIDTH-1:0] wr_data,
    output      logic                  in_ready,
    output      logic                  out_valid,
    input  wire logic                  out_ready,
    output      logic [DATA_W-1:0]     out_max,
    output      logic                  out_last
);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam logic [ELEM_WIDTH-1:0] ELEM_SIGN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    logic                  s1_valid_reg;
    logic [ELEM_WIDTH-1:0] s1_elem_reg;
    logic [IDX_W-1:0]      s1_idx_reg;
    tamr_flags_t           s1_flags_reg;

    logic                  wr_valid_reg;
    logic [IDX_W-1:0]      wr_idx_reg;
    logic [ELEM_WIDTH-1:0] wr_data_reg;

    logic [DATA_W-1:0]     fifo_max_reg [FIFO_DEPTH];
    logic                  fifo_last_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    wr_ptr_reg;
    logic [FIFO_AW-1:0]    rd_ptr_reg;
    logic [FIFO_AW:0]      occ_reg, occ_next;

    logic [ELEM_WIDTH-1:0] kept;
    logic [ELEM_WIDTH-1:0] upd_max;
    logic                  push;
    logic                  pop;

    // a < b under the element kind; any NaN and the two zeros compare false
    function automatic logic elem_less(input logic [KIND_W-1:0] k,
                                       input logic [ELEM_WIDTH-1:0] a,
                                       input logic [ELEM_WIDTH-1:0] b);
        logic [DATA_W-1:0] fa, fb, ka, kb;
        begin
            fa = DATA_W'(a);
            fb = DATA_W'(b);
            ka = fa[31] ? ~fa : (fa | 32'h8000_0000);
            kb = fb[31] ? ~fb : (fb | 32'h8000_0000);
            case (k)
                KIND_SIGNED: elem_less = (a ^ ELEM_SIGN) < (b ^ ELEM_SIGN);
                KIND_FLOAT:
                begin
                    if (fa[30:0] > 31'h7F80_0000 || fb[30:0] > 31'h7F80_0000)
                    begin
                        elem_less = 1'b0;
                    end
                    else if ((fa[30:0] | fb[30:0]) == '0)
                    begin
                        elem_less = 1'b0;
                    end
                    else
                    begin
                        elem_less = ka < kb;
                    end
                end
                default:     elem_less = a < b;
            endcase
        end
    endfunction

    // RAM read was issued at accept; the write of the previous beat lands
    // on the same edge, so it is forwarded from here
    assign kept    = (wr_valid_reg && wr_idx_reg == s1_idx_reg) ? wr_data_reg : rd_data;
    assign upd_max = (s1_flags_reg.first || elem_less(kind, kept, s1_elem_reg))
                     ? s1_elem_reg : kept;

    assign wr_en   = s1_valid_reg;
    assign wr_addr = s1_idx_reg;
    assign wr_data = upd_max;

    assign push      = s1_valid_reg && s1_flags_reg.emit;
    assign out_valid = (occ_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_max   = fifo_max_reg[rd_ptr_reg];
    assign out_last  = fifo_last_reg[rd_ptr_reg];

    // a beat taken now pushes once it reaches stage 1, after the one now there
    assign in_ready = (occ_reg + {{FIFO_AW{1'b0}}, push}) <= (FIFO_AW + 1)'(FIFO_DEPTH - 1);

    always_comb
    begin
        occ_next = occ_reg;
        if (push && !pop)
        begin
            occ_next = occ_reg + (FIFO_AW + 1)'(1);
        end
        else if (pop && !push)
        begin
            occ_next = occ_reg - (FIFO_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            occ_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (s1_valid_reg)
            begin
                wr_valid_reg <= 1'b1;
            end
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_elem_reg  <= elem;
            s1_idx_reg   <= idx;
            s1_flags_reg <= flags;
        end
        if (s1_valid_reg)
        begin
            wr_idx_reg  <= s1_idx_reg;
            wr_data_reg <= upd_max;
        end
        if (push)
        begin
            fifo_max_reg[wr_ptr_reg]  <= DATA_W'(upd_max);
            fifo_last_reg[wr_ptr_reg] <= s1_flags_reg.last;
        end
    end

`include "tensor_axis_max_reduce_assert.svh"

    `TAMR_ASSERT_IMPL(a_fifo_no_overflow, push && !pop, occ_reg < (FIFO_AW + 1)'(FIFO_DEPTH))
    `TAMR_ASSERT_NEXT(a_fwd_tracks_write, s1_valid_reg, wr_valid_reg && wr_idx_reg == $past(s1_idx_reg))
    `TAMR_ASSERT_NEXT(a_fwd_data_tracks, s1_valid_reg, wr_data_reg == $past(upd_max))
    `TAMR_ASSERT_NEXT(a_push_counts, push && !pop, occ_reg == $past(occ_reg) + (FIFO_AW + 1)'(1))

endmodule

`default_nettype wire
